// ===== hw/rtl/aes128_pkg.sv =====
// Package: AES-128 types, S-box tables and round functions.
package aes128_pkg;

    localparam int KeyWords   = 44;
    localparam int RoundCount = 10;
    localparam int KwAddrW    = 6;
    localparam int RegIdxW    = 1;

    localparam logic [RegIdxW-1:0] RegKeyHigh = 1'b0;
    localparam logic [RegIdxW-1:0] RegKeyLow  = 1'b1;

    typedef logic [KwAddrW-1:0] kw_addr_t;
    typedef logic [3:0] round_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic   load;      // load input block and add round key 0
        logic   round;     // run one cipher round
        logic   last;      // final round: no column mix
        logic   dec;       // inverse direction
        logic   out_load;  // capture state into output register
    } dp_cmd_t;

    // Key expansion commands.
    typedef struct packed {
        logic       start;
        logic       step;
        logic [5:0] idx;   // current word index 4..43
    } ke_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] w, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] r;
        for (int i = 0; i < 4; i++) begin
            a[i]  = w[31-8*i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
            m2[i] = x2[i];
            m3[i] = x2[i] ^ a[i];
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        for (int i = 0; i < 4; i++) begin
            if (inv)
                r[31-8*i -: 8] = me[i] ^ mb[(i+1)%4] ^ md[(i+2)%4] ^ m9[(i+3)%4];
            else
                r[31-8*i -: 8] = m2[i] ^ m3[(i+1)%4] ^ a[(i+2)%4] ^ a[(i+3)%4];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/aes128_block_cipher_unit.sv =====
// An accepted item goes through key add, 10 rounds and the output register before result valid.
// The single shared round unit works on one item at a time; no new item is accepted until the last is loaded.
// A key write re-expands the key, one round-key word per cycle.
// rst_n clears control state and key registers; round keys are undefined until a key write.
// The output register holds a result while the next item is accepted.
// Top level: AES-128 encrypt/decrypt unit with stream ports and key config port.
module aes128_block_cipher_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,      // req_type
    input  logic [127:0] s_tdata,      // [63:0] block_high, [127:64] block_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata       // [63:0] result_high, [127:64] result_low
);
    import aes128_pkg::*;

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    ke_cmd_t      ke_cmd;
    dp_cmd_t      dp_cmd;
    kw_addr_t     rk_addr;
    logic         rk_dec;
    logic [127:0] rkey;
    logic [127:0] result;
    logic         in_fire;

    // Latch key halves; expansion starts the cycle after.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegKeyHigh: key_high_reg <= cfg_data;
                RegKeyLow:  key_low_reg  <= cfg_data;
                default:    key_low_reg  <= key_low_reg;
            endcase
        end
    end

    assign in_fire = s_tvalid && s_tready;

    aes128_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_hit   (1'b1),
        .in_fire   (in_fire),
        .in_dec    (s_tuser),
        .out_free  (m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .ke_cmd    (ke_cmd),
        .dp_cmd    (dp_cmd),
        .rk_addr   (rk_addr),
        .rk_dec    (rk_dec)
    );

    aes128_keyexp u_keyexp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ke_cmd),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .rd_addr  (rk_addr),
        .rd_dec   (rk_dec),
        .rd_data  (rkey)
    );

    // Hold the block until the key-add cycle.
    logic [127:0] blk_reg;
    always_ff @(posedge clk)
    begin
        if (in_fire)
            blk_reg <= {s_tdata[63:0], s_tdata[127:64]};
    end

    aes128_datapath u_dp (
        .clk    (clk),
        .cmd    (dp_cmd),
        .blk_in (blk_reg),
        .rkey   (rkey),
        .result (result)
    );

    assign m_tdata = {result[63:0], result[127:64]};

`ifndef ASSERT_OFF
    a_no_load_in_key: assert property (@(posedge clk) disable iff (!rst_n)
        ke_cmd.step |-> !dp_cmd.load && !dp_cmd.round) else $error("round during key expansion");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready) else $error("ready during item work");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
`endif

endmodule

// ===== hw/rtl/aes128_keyexp.sv =====
// Key expansion: one forward word per cycle while stepped, stored a row at a time into both round-key memories.
module aes128_keyexp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aes128_pkg::ke_cmd_t   cmd,
    input  logic [63:0]           key_high,
    input  logic [63:0]           key_low,
    input  aes128_pkg::kw_addr_t  rd_addr,
    input  logic                  rd_dec,
    output logic [127:0]          rd_data
);
    import aes128_pkg::*;

    // Round keys are stored one round (four words) per row.
    logic [127:0] fwd_mem [11];
    logic [127:0] inv_mem [11];
    logic [127:0] win_reg;      // last four words, w[i-4]..w[i-1]
    logic [7:0]   rc_reg;
    logic [31:0]  t;
    logic [31:0]  w_new;
    logic [127:0] row;
    logic [3:0]   rnum;
    logic [127:0] inv_row;

    always_comb
    begin
        t = win_reg[31:0];
        if (cmd.idx[1:0] == 2'd0)
            t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
                ^ {rc_reg, 24'd0};
        w_new = win_reg[127:96] ^ t;
        row   = {win_reg[95:0], w_new};
        rnum  = cmd.idx[5:2];
        for (int j = 0; j < 4; j++)
            inv_row[127-32*j -: 32] = (rnum == 4'd10) ? row[127-32*j -: 32]
                                      : mix_word(row[127-32*j -: 32], 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg <= 8'h01;
        end
        else if (cmd.start)
        begin
            rc_reg <= 8'h01;
        end
        else if (cmd.step && cmd.idx[1:0] == 2'd0)
        begin
            rc_reg <= xtime(rc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            win_reg    <= {key_high, key_low};
            fwd_mem[0] <= {key_high, key_low};
            inv_mem[10] <= {key_high, key_low};
        end
        else if (cmd.step)
        begin
            win_reg <= row;
            if (cmd.idx[1:0] == 2'd3)
            begin
                fwd_mem[rnum]          <= row;
                inv_mem[4'd10 - rnum]  <= inv_row;
            end
        end
        rd_data <= rd_dec ? inv_mem[rd_addr[5:2]] : fwd_mem[rd_addr[5:2]];
    end

endmodule

// ===== hw/rtl/aes128_datapath.sv =====
// Cipher datapath: state register, one round per cycle, output register.
module aes128_datapath (
    input  logic                clk,
    input  aes128_pkg::dp_cmd_t cmd,
    input  logic [127:0]        blk_in,
    input  logic [127:0]        rkey,
    output logic [127:0]        result
);
    import aes128_pkg::*;

    logic [127:0] state_reg;
    logic [127:0] result_reg;
    logic [7:0]   sb [16];
    logic [127:0] mixed;
    logic [127:0] rnd_out;
    logic [1:0]   src;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = cmd.dec ? 2'((c - r + 4) & 3) : 2'((c + r) & 3);
                sb[4*c+r] = cmd.dec ? inv_sbox(state_reg[127-8*(4*src+r) -: 8])
                                    : sbox(state_reg[127-8*(4*src+r) -: 8]);
            end
        for (int c = 0; c < 4; c++)
            mixed[127-32*c -: 32] = cmd.last
                ? {sb[4*c], sb[4*c+1], sb[4*c+2], sb[4*c+3]}
                : mix_word({sb[4*c], sb[4*c+1], sb[4*c+2], sb[4*c+3]}, cmd.dec);
        rnd_out = mixed ^ rkey;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            state_reg <= blk_in ^ rkey;
        else if (cmd.round)
            state_reg <= rnd_out;
        if (cmd.out_load)
            result_reg <= state_reg;
    end

    assign result = result_reg;

endmodule

// ===== hw/rtl/aes128_ctrl.sv =====
// Controller: key expansion sequencing and round sequencing.
module aes128_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_hit,
    input  logic                  in_fire,
    input  logic                  in_dec,
    input  logic                  out_free,
    output logic                  in_ready,
    output logic                  out_valid,
    output aes128_pkg::ke_cmd_t   ke_cmd,
    output aes128_pkg::dp_cmd_t   dp_cmd,
    output aes128_pkg::kw_addr_t  rk_addr,
    output logic                  rk_dec
);
    import aes128_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_KEY  = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t     st_reg, st_next;
    logic [5:0] kidx_reg, kidx_next;
    round_t     rnd_reg, rnd_next;
    logic       dec_reg, dec_next;
    logic       ov_reg, ov_next;
    logic       kstart_reg;

    always_comb
    begin
        st_next   = st_reg;
        kidx_next = kidx_reg;
        rnd_next  = rnd_reg;
        dec_next  = dec_reg;
        ov_next   = ov_reg;
        dp_cmd    = '0;
        dp_cmd.dec = dec_reg;
        ke_cmd.start = kstart_reg;
        ke_cmd.step  = (st_reg == S_KEY);
        ke_cmd.idx   = kidx_reg;
        in_ready  = (st_reg == S_IDLE) && !cfg_we && !kstart_reg;
        if (out_free)
            ov_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (kstart_reg)
                begin
                    st_next   = S_KEY;
                    kidx_next = 6'd4;
                end
                else if (in_fire)
                begin
                    // key row 0 is fetched this cycle
                    st_next  = S_RUN;
                    rnd_next = '0;
                    dec_next = in_dec;
                end
            end
            S_KEY:
            begin
                // a new key write restarts the expansion
                if (kstart_reg)
                    kidx_next = 6'd4;
                else
                begin
                    kidx_next = kidx_reg + 6'd1;
                    if (kidx_reg == 6'(KeyWords - 1))
                        st_next = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (rnd_reg == '0)
                    dp_cmd.load = 1'b1;
                else
                begin
                    dp_cmd.round = 1'b1;
                    dp_cmd.last  = (rnd_reg == 4'(RoundCount));
                end
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == 4'(RoundCount))
                    st_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
        // fetch address runs one round ahead of the datapath
        rk_addr = (st_reg == S_RUN && rnd_reg != 4'(RoundCount))
                  ? kw_addr_t'({rnd_next, 2'b00}) : '0;
        rk_dec  = (st_reg == S_IDLE) ? in_dec : dec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            kidx_reg   <= '0;
            rnd_reg    <= '0;
            dec_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            kstart_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            kidx_reg   <= kidx_next;
            rnd_reg    <= rnd_next;
            dec_reg    <= dec_next;
            ov_reg     <= ov_next;
            kstart_reg <= cfg_we && cfg_hit;
        end
    end

    assign out_valid = ov_reg;

endmodule
